// ===== hdl/ccs_pkg.sv =====
// ccs_pkg: beat types and constants shared by the circle column span block.
// No dependencies; every other file in hdl/ refers to it by scoped name.
package ccs_pkg;

    // Radicand r*r - dx*dx stays below 2^22; its floor root fits in 11 bits.
    localparam int unsigned ARG_W     = 22;
    localparam int unsigned ROOT_W    = 11;
    localparam int unsigned ROOT_CELLS = ARG_W / 2;

    typedef struct packed {
        logic signed [11:0] center_x;
        logic signed [11:0] center_y;
        logic signed [11:0] radius;
        logic [8:0]         column;
        logic [15:0]        fill_color;
    } req_t;

    typedef struct packed {
        logic        draws;
        logic [7:0]  row_start;
        logic [7:0]  row_end;
        logic [16:0] pixel_address;
        logic [15:0] pixel_color;
    } res_t;

    // One beat travelling down the square-root chain.
    typedef struct packed {
        logic               valid;
        logic               ok;
        logic signed [11:0] cy;
        logic [8:0]         col;
        logic [15:0]        color;
        logic [ARG_W-1:0]   rem;
        logic [ARG_W-1:0]   root;
    } cell_bus_t;

endpackage

// ===== hdl/circle_column_span.sv =====
// circle_column_span: top level, one filled-circle column span per beat.
// Depends on ccs_pkg, ccs_prep, ccs_root_cell, ccs_span.
//
//   channel   ports             handshake
//   -------   ---------------   -----------------------------------------
//   command   start, request    taken on a clock edge with start high, busy low
//   status    busy              always low: the pipeline never stalls
//   result    done, result      one cycle, marked by done; cannot be held off
//
// Throughput is one beat per clock. The pipeline has 17 register stages:
// 3 prep stages (range test, squares, radicand), 11 root cells (one bit
// pair of the 22-bit radicand each), 3 span stages (clamp, row times WIDTH,
// address add). Reset clears only the valid bits of the chain; payload
// registers are not reset. The receiver cannot stall, so no accepted beat
// is ever held back.
module circle_column_span #(
    parameter int WIDTH  = 320,
    parameter int HEIGHT = 240
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ccs_pkg::req_t  request,
    output logic           done,
    output ccs_pkg::res_t  result
);

    // Links between the stages: link[0] leaves prep, link[CELLS] enters span.
    ccs_pkg::cell_bus_t link [0:ccs_pkg::ROOT_CELLS];

    // Nothing ever holds the pipeline; accept a beat on every edge.
    assign busy = 1'b0;

    ccs_prep #(
        .WIDTH (WIDTH)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .request  (request),
        .bus      (link[0])
    );

    // Advance the radicand through the root cells, one bit pair per cell.
    for (genvar k = 0; k < ccs_pkg::ROOT_CELLS; k++)
    begin : g_cell
        ccs_root_cell #(
            .INDEX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bus_in  (link[k]),
            .bus_out (link[k+1])
        );
    end

    ccs_span #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_span (
        .clk    (clk),
        .rst_n  (rst_n),
        .bus    (link[ccs_pkg::ROOT_CELLS]),
        .done   (done),
        .result (result)
    );

endmodule

// ===== hdl/ccs_prep.sv =====
// ccs_prep: column range test and radicand r*r - dx*dx, three register stages.
// Depends on ccs_pkg.
module ccs_prep #(
    parameter int WIDTH = 320
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ccs_pkg::req_t     request,
    output ccs_pkg::cell_bus_t bus
);

    localparam logic signed [13:0] XMAX = 14'(WIDTH - 1);

    logic signed [13:0] cx14, r14, col14, lo, hi, xs, xe, dx, adx;
    logic               ok_next;

    assign cx14  = {{2{request.center_x[11]}}, request.center_x};
    assign r14   = {{2{request.radius[11]}}, request.radius};
    assign col14 = {5'b0, request.column};
    assign lo    = cx14 - r14;
    assign hi    = cx14 + r14;
    assign xs    = (lo < 0) ? 14'sd0 : ((lo > XMAX) ? XMAX : lo);
    assign xe    = (hi < 0) ? 14'sd0 : ((hi > XMAX) ? XMAX : hi);
    assign dx    = col14 - cx14;
    assign adx   = (dx < 0) ? -dx : dx;
    assign ok_next = (r14 > 0) && (col14 >= xs) && (col14 < xe);

    // Stage 1: range test done, magnitudes held.
    logic               v1_reg, ok1_reg;
    logic [10:0]        r1_reg, dx1_reg;
    logic signed [11:0] cy1_reg;
    logic [8:0]         col1_reg;
    logic [15:0]        color1_reg;
    // Stage 2: squares.
    logic               v2_reg, ok2_reg;
    logic [21:0]        rsq2_reg, dxsq2_reg;
    logic signed [11:0] cy2_reg;
    logic [8:0]         col2_reg;
    logic [15:0]        color2_reg;
    // Stage 3: radicand.
    logic               v3_reg, ok3_reg;
    logic [21:0]        arg3_reg;
    logic signed [11:0] cy3_reg;
    logic [8:0]         col3_reg;
    logic [15:0]        color3_reg;

    logic [21:0] rsq_next, dxsq_next, arg_next;

    assign rsq_next  = {11'b0, r1_reg} * {11'b0, r1_reg};
    assign dxsq_next = {11'b0, dx1_reg} * {11'b0, dx1_reg};
    assign arg_next  = rsq2_reg - dxsq2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok1_reg    <= ok_next;
        r1_reg     <= request.radius[10:0];
        dx1_reg    <= adx[10:0];
        cy1_reg    <= request.center_y;
        col1_reg   <= request.column;
        color1_reg <= request.fill_color;

        ok2_reg    <= ok1_reg;
        rsq2_reg   <= rsq_next;
        dxsq2_reg  <= dxsq_next;
        cy2_reg    <= cy1_reg;
        col2_reg   <= col1_reg;
        color2_reg <= color1_reg;

        ok3_reg    <= ok2_reg;
        arg3_reg   <= arg_next;
        cy3_reg    <= cy2_reg;
        col3_reg   <= col2_reg;
        color3_reg <= color2_reg;
    end

    always_comb
    begin
        bus.valid = v3_reg;
        bus.ok    = ok3_reg;
        bus.cy    = cy3_reg;
        bus.col   = col3_reg;
        bus.color = color3_reg;
        bus.rem   = arg3_reg;
        bus.root  = '0;
    end

endmodule

// ===== hdl/ccs_root_cell.sv =====
// ccs_root_cell: one digit of the floor square root, registered.
// Depends on ccs_pkg. INDEX picks which bit pair this cell resolves.
module ccs_root_cell #(
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ccs_pkg::cell_bus_t bus_in,
    output ccs_pkg::cell_bus_t bus_out
);

    localparam logic [ccs_pkg::ARG_W-1:0] BIT =
        (ccs_pkg::ARG_W)'(1) << (ccs_pkg::ARG_W - 2 - 2 * INDEX);

    logic [ccs_pkg::ARG_W-1:0] trial;
    logic [ccs_pkg::ARG_W-1:0] rem_next, root_next;
    logic                      valid_reg;
    ccs_pkg::cell_bus_t        data_reg, data_next;

    assign trial = bus_in.root + BIT;

    always_comb
    begin
        if (bus_in.rem >= trial)
        begin
            rem_next  = bus_in.rem - trial;
            root_next = (bus_in.root >> 1) + BIT;
        end
        else
        begin
            rem_next  = bus_in.rem;
            root_next = bus_in.root >> 1;
        end
    end

    // Pass the beat on with this digit resolved.
    always_comb
    begin
        data_next      = bus_in;
        data_next.rem  = rem_next;
        data_next.root = root_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= bus_in.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        bus_out       = data_reg;
        bus_out.valid = valid_reg;
    end

endmodule

// ===== hdl/ccs_span.sv =====
// ccs_span: row clamp, empty-span test and framebuffer address, three stages.
// Depends on ccs_pkg.
module ccs_span #(
    parameter int WIDTH  = 320,
    parameter int HEIGHT = 240
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ccs_pkg::cell_bus_t bus,
    output logic               done,
    output ccs_pkg::res_t      result
);

    localparam logic signed [13:0] YMAX  = 14'(HEIGHT - 1);
    localparam logic [11:0]        WID_C = 12'(WIDTH);

    logic signed [13:0] cy14, h14, lo, hi, ys14, ye14;
    logic               draws_next;

    assign cy14 = {{2{bus.cy[11]}}, bus.cy};
    assign h14  = {3'b0, bus.root[ccs_pkg::ROOT_W-1:0]};
    assign lo   = cy14 - h14;
    assign hi   = cy14 + h14;
    assign ys14 = (lo < 0) ? 14'sd0 : ((lo > YMAX) ? YMAX : lo);
    assign ye14 = (hi < 0) ? 14'sd0 : ((hi > YMAX) ? YMAX : hi);
    assign draws_next = bus.ok && (ys14 < ye14);

    logic        v1_reg, v2_reg, done_reg;
    logic        d1_reg, d2_reg;
    logic [10:0] ys1_reg, ye1_reg, ys2_reg, ye2_reg;
    logic [8:0]  col1_reg, col2_reg;
    logic [15:0] color1_reg, color2_reg;
    logic [22:0] prod2_reg;
    logic [23:0] addr_next;
    ccs_pkg::res_t res_reg, res_next;

    assign addr_next = {1'b0, prod2_reg} + {15'b0, col2_reg};

    // Drop every field to zero when nothing is drawn.
    always_comb
    begin
        res_next = '0;
        if (d2_reg)
        begin
            res_next.draws         = 1'b1;
            res_next.row_start     = ys2_reg[7:0];
            res_next.row_end       = ye2_reg[7:0];
            res_next.pixel_address = addr_next[16:0];
            res_next.pixel_color   = color2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= bus.valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg     <= draws_next;
        ys1_reg    <= ys14[10:0];
        ye1_reg    <= ye14[10:0];
        col1_reg   <= bus.col;
        color1_reg <= bus.color;

        d2_reg     <= d1_reg;
        ys2_reg    <= ys1_reg;
        ye2_reg    <= ye1_reg;
        prod2_reg  <= {12'b0, ys1_reg} * {11'b0, WID_C};
        col2_reg   <= col1_reg;
        color2_reg <= color1_reg;

        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
